>>> design/mku_pkg.sv
// ----------------------------------------------------------------------------
// mku_pkg: shared types and constants for the mixed knapsack update engine
// Field widths, value saturation limit, sequencer states and the
// result bundle of the shared add/compare unit.
// ----------------------------------------------------------------------------
package mku_pkg;

    // Default table depth (largest budget held)
    localparam int MAX_CAPACITY_DEF = 1024;

    // Port field widths
    localparam int CAP_IN_W = 11;
    localparam int WEIGHT_W = 11;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 10;

    // Chunk weight width (one copy times up to 1023 copies) and chunk multiplier width
    localparam int CHUNK_W_W = WEIGHT_W + COUNT_W;
    localparam int KMUL_W    = WEIGHT_W;

    // Table entry width and saturation limit
    localparam int          BEST_W   = 26;
    localparam logic [25:0] BEST_MAX = 26'h3FF_FFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHUNK,
        ST_MULT,
        ST_SETUP,
        ST_READ,
        ST_UPDATE,
        ST_RES_READ,
        ST_RES_OUT
    } mku_state_t;

    // Result of the shared add/compare unit
    typedef struct packed {
        logic              better;
        logic [BEST_W-1:0] value;
    } mku_alu_out_t;

endpackage

>>> design/mku_table.sv
// ----------------------------------------------------------------------------
// mku_table: best-value table memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mku_table #(
    parameter  int DEPTH  = mku_pkg::MAX_CAPACITY_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [mku_pkg::BEST_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_a_addr,
    input  logic [ADDR_W-1:0]          rd_b_addr,
    output logic [mku_pkg::BEST_W-1:0] rd_a_data,
    output logic [mku_pkg::BEST_W-1:0] rd_b_data
);

    logic [mku_pkg::BEST_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

>>> design/mku_alu.sv
// ----------------------------------------------------------------------------
// mku_alu: shared saturating add and compare unit
// Forms candidate = lower entry + chunk value (saturated) and flags it
// when it beats the current entry.
// ----------------------------------------------------------------------------
module mku_alu (
    input  logic [mku_pkg::BEST_W-1:0] lower,
    input  logic                       lower_zero,
    input  logic [mku_pkg::BEST_W-1:0] current,
    input  logic [mku_pkg::BEST_W-1:0] gain,
    output mku_pkg::mku_alu_out_t      result
);

    logic [mku_pkg::BEST_W-1:0] lower_eff;
    logic [mku_pkg::BEST_W:0]   sum;
    logic [mku_pkg::BEST_W-1:0] cand;

    // Budget zero reads as zero value
    assign lower_eff = lower_zero ? '0 : lower;

    // Saturating add
    assign sum  = {1'b0, lower_eff} + {1'b0, gain};
    assign cand = sum[mku_pkg::BEST_W] ? mku_pkg::BEST_MAX : sum[mku_pkg::BEST_W-1:0];

    // Flag the candidate when it is strictly larger than the current entry
    always_comb
    begin
        result.value  = cand;
        result.better = (cand > current);
    end

endmodule

>>> design/mixed_knapsack_update.sv
// ----------------------------------------------------------------------------
// mixed_knapsack_update: mixed knapsack best-value engine
// Sequencer, capacity register and datapath around the shared
// add/compare unit and the best-value table.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one item; busy stays high until
// the item is finished, and done then pulses for one cycle with best_value,
// which must be captured in that cycle since there is no way to stall it.
// All work runs through one add/compare unit and one table port pair, each
// table entry touched taking a read state and an update state. An unlimited
// item (count 0) makes one pass over the table when it fits and none when it
// does not; a limited item is split into up to ten chunks (1, 2, 4, 8 copies
// and so on, plus a remainder), each with its own setup and a pass over the
// table when it fits. A zero-weight item changes no entry. done comes in the
// same cycle that busy drops. After reset and after every write of capacity
// the table is cleared, one entry a cycle, over all MAX_CAPACITY entries,
// with busy high throughout.
// ----------------------------------------------------------------------------
module mixed_knapsack_update #(
    parameter int MAX_CAPACITY = mku_pkg::MAX_CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic                         capacity_we,
    input  logic [mku_pkg::CAP_IN_W-1:0] capacity,
    input  logic [mku_pkg::WEIGHT_W-1:0] item_weight,
    input  logic [mku_pkg::VALUE_W-1:0]  item_value,
    input  logic [mku_pkg::COUNT_W-1:0]  item_count,
    output logic [mku_pkg::BEST_W-1:0]   best_value
);

    localparam int CW     = $clog2(MAX_CAPACITY + 1);
    localparam int ADDR_W = $clog2(MAX_CAPACITY);
    localparam int CHW    = mku_pkg::CHUNK_W_W;

    // Control registers
    mku_pkg::mku_state_t state_reg, state_next;
    logic [CW-1:0]       cap_reg, cap_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                done_reg, done_next;

    // Payload registers
    logic [mku_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [mku_pkg::VALUE_W-1:0]  v_reg, v_next;
    logic [mku_pkg::COUNT_W-1:0]  nrem_reg, nrem_next;
    logic [mku_pkg::KMUL_W-1:0]   k_reg, k_next;
    logic [mku_pkg::COUNT_W-1:0]  mult_reg, mult_next;
    logic                         unl_reg, unl_next;
    logic [CHW-1:0]               cw_reg, cw_next;
    logic [mku_pkg::BEST_W-1:0]   cv_reg, cv_next;
    logic                         lo_zero_reg, lo_zero_next;
    logic [mku_pkg::BEST_W-1:0]   best_value_reg, best_value_next;

    // Table and unit hookup
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [mku_pkg::BEST_W-1:0] wr_data;
    logic [ADDR_W-1:0]          rd_a_addr;
    logic [ADDR_W-1:0]          rd_b_addr;
    logic [mku_pkg::BEST_W-1:0] rd_a_data;
    logic [mku_pkg::BEST_W-1:0] rd_b_data;
    mku_pkg::mku_alu_out_t      alu_out;

    // Derived terms
    logic [31:0]   cap_in32;
    logic [CW-1:0] cap_sat;
    logic [CW-1:0] cw_pos;
    logic [CW-1:0] diff;
    logic          cw_fits;
    logic          chunk_full;
    logic          pass_last;

    // Capacity write saturates to 1..MAX_CAPACITY
    always_comb
    begin
        cap_in32 = 32'(capacity);
        if (cap_in32 == 32'd0)
        begin
            cap_sat = CW'(1);
        end
        else if (cap_in32 > 32'(MAX_CAPACITY))
        begin
            cap_sat = CW'(MAX_CAPACITY);
        end
        else
        begin
            cap_sat = CW'(cap_in32);
        end
    end

    assign cw_pos     = cw_reg[CW-1:0];
    assign diff       = pos_reg - cw_pos;
    assign cw_fits    = (cw_reg <= CHW'(cap_reg));
    assign chunk_full = ({1'b0, nrem_reg} >= k_reg);
    assign pass_last  = unl_reg ? (pos_reg == cap_reg) : (pos_reg == cw_pos);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mku_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MAX_CAPACITY - 1))
                begin
                    state_next = mku_pkg::ST_IDLE;
                end
            end
            mku_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item_weight == '0)
                    begin
                        state_next = mku_pkg::ST_RES_READ;
                    end
                    else if (item_count == '0)
                    begin
                        state_next = mku_pkg::ST_MULT;
                    end
                    else
                    begin
                        state_next = mku_pkg::ST_CHUNK;
                    end
                end
            end
            mku_pkg::ST_CHUNK:
            begin
                if (chunk_full || (nrem_reg != '0))
                begin
                    state_next = mku_pkg::ST_MULT;
                end
                else
                begin
                    state_next = mku_pkg::ST_RES_READ;
                end
            end
            mku_pkg::ST_MULT:
            begin
                state_next = mku_pkg::ST_SETUP;
            end
            mku_pkg::ST_SETUP:
            begin
                if (cw_fits)
                begin
                    state_next = mku_pkg::ST_READ;
                end
                else if (unl_reg)
                begin
                    state_next = mku_pkg::ST_RES_READ;
                end
                else
                begin
                    state_next = mku_pkg::ST_CHUNK;
                end
            end
            mku_pkg::ST_READ:
            begin
                state_next = mku_pkg::ST_UPDATE;
            end
            mku_pkg::ST_UPDATE:
            begin
                if (!pass_last)
                begin
                    state_next = mku_pkg::ST_READ;
                end
                else if (unl_reg)
                begin
                    state_next = mku_pkg::ST_RES_READ;
                end
                else
                begin
                    state_next = mku_pkg::ST_CHUNK;
                end
            end
            mku_pkg::ST_RES_READ:
            begin
                state_next = mku_pkg::ST_RES_OUT;
            end
            mku_pkg::ST_RES_OUT:
            begin
                state_next = mku_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mku_pkg::ST_IDLE;
            end
        endcase
        // A capacity write restarts the clearing pass
        if (capacity_we)
        begin
            state_next = mku_pkg::ST_CLEAR;
        end
    end

    // Datapath next values
    always_comb
    begin
        cap_next        = cap_reg;
        clr_addr_next   = clr_addr_reg;
        pos_next        = pos_reg;
        done_next       = (state_reg == mku_pkg::ST_RES_OUT);
        w_next          = w_reg;
        v_next          = v_reg;
        nrem_next       = nrem_reg;
        k_next          = k_reg;
        mult_next       = mult_reg;
        unl_next        = unl_reg;
        cw_next         = cw_reg;
        cv_next         = cv_reg;
        lo_zero_next    = (diff == '0);
        best_value_next = best_value_reg;

        case (state_reg)
            mku_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            mku_pkg::ST_IDLE:
            begin
                w_next    = item_weight;
                v_next    = item_value;
                nrem_next = item_count;
                k_next    = mku_pkg::KMUL_W'(1);
                mult_next = mku_pkg::COUNT_W'(1);
                unl_next  = (item_count == '0);
            end
            mku_pkg::ST_CHUNK:
            begin
                // Binary chunk while it fits, then the remainder
                if (chunk_full)
                begin
                    mult_next = k_reg[mku_pkg::COUNT_W-1:0];
                    nrem_next = nrem_reg - k_reg[mku_pkg::COUNT_W-1:0];
                    k_next    = {k_reg[mku_pkg::KMUL_W-2:0], 1'b0};
                end
                else
                begin
                    mult_next = nrem_reg;
                    nrem_next = '0;
                end
            end
            mku_pkg::ST_MULT:
            begin
                cw_next = CHW'(w_reg) * CHW'(mult_reg);
                cv_next = mku_pkg::BEST_W'(v_reg) * mku_pkg::BEST_W'(mult_reg);
            end
            mku_pkg::ST_SETUP:
            begin
                pos_next = unl_reg ? cw_pos : cap_reg;
            end
            mku_pkg::ST_UPDATE:
            begin
                pos_next = unl_reg ? (pos_reg + CW'(1)) : (pos_reg - CW'(1));
            end
            mku_pkg::ST_RES_OUT:
            begin
                best_value_next = rd_b_data;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        if (capacity_we)
        begin
            cap_next      = cap_sat;
            clr_addr_next = '0;
        end
    end

    // Table port control
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = ADDR_W'(pos_reg - CW'(1));
        wr_data   = alu_out.value;
        rd_a_addr = ADDR_W'(diff - CW'(1));
        rd_b_addr = ADDR_W'(pos_reg - CW'(1));
        case (state_reg)
            mku_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            mku_pkg::ST_UPDATE:
            begin
                wr_en = alu_out.better;
            end
            mku_pkg::ST_RES_READ:
            begin
                rd_b_addr = ADDR_W'(cap_reg - CW'(1));
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mku_pkg::ST_CLEAR;
            cap_reg      <= CW'(MAX_CAPACITY);
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            clr_addr_reg <= clr_addr_next;
            pos_reg      <= pos_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        v_reg          <= v_next;
        nrem_reg       <= nrem_next;
        k_reg          <= k_next;
        mult_reg       <= mult_next;
        unl_reg        <= unl_next;
        cw_reg         <= cw_next;
        cv_reg         <= cv_next;
        lo_zero_reg    <= lo_zero_next;
        best_value_reg <= best_value_next;
    end

    // Best-value table
    mku_table #(
        .DEPTH (MAX_CAPACITY)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // Shared add/compare unit
    mku_alu u_alu (
        .lower      (rd_a_data),
        .lower_zero (lo_zero_reg),
        .current    (rd_b_data),
        .gain       (cv_reg),
        .result     (alu_out)
    );

    // Outputs
    assign busy       = (state_reg != mku_pkg::ST_IDLE);
    assign done       = done_reg;
    assign best_value = best_value_reg;

endmodule

>>> design/mku_checker.sv
// ----------------------------------------------------------------------------
// mku_checker: port-level checks for the mixed knapsack update engine
// Request/result sequencing seen on the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
module mku_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic capacity_we
);

    // A result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted request keeps the block busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // A result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // A capacity write starts the clearing pass
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        capacity_we |=> busy)
        else $error("capacity write did not start table clear");

endmodule

bind mixed_knapsack_update mku_checker u_mku_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .capacity_we (capacity_we)
);
